// ===== hw/rtl/dmdp_pkg.sv =====
// ----------------------------------------------------------------------------
// dmdp_pkg
// Types and constants for the dual-modulus RNS dot product core.
// ----------------------------------------------------------------------------
package dmdp_pkg;

  localparam int RES_W     = 28;
  localparam int PROD_W    = 2 * RES_W;
  localparam int SUM_W     = 64;
  localparam int LANES     = 4;
  localparam int MAX_TERMS = 256;
  localparam int CNT_W     = 9;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;
  localparam int STEP_W    = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [RES_W-1:0] MODULUS_0_RST = RES_W'(268369921);
  localparam logic [RES_W-1:0] MODULUS_1_RST = RES_W'(249561089);
  localparam logic [STEP_W-1:0] LAST_STEP    = STEP_W'(SUM_W - 1);
  localparam logic [CNT_W-1:0]  MAX_CNT      = CNT_W'(MAX_TERMS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_1 = CFG_IDX_W'(1);

  // lane order: row0/mod0, row1/mod0, row0/mod1, row1/mod1
  localparam int LANE_R0M0 = 0;
  localparam int LANE_R1M0 = 1;
  localparam int LANE_R0M1 = 2;
  localparam int LANE_R1M1 = 3;

  typedef struct packed {
    logic [RES_W-1:0] db_res0;
    logic [RES_W-1:0] db_res1;
    logic [RES_W-1:0] qa_row0_res0;
    logic [RES_W-1:0] qa_row0_res1;
    logic [RES_W-1:0] qa_row1_res0;
    logic [RES_W-1:0] qa_row1_res1;
    logic             last_term;
  } in_item_t;

  typedef struct packed {
    logic [RES_W-1:0] row0_mod0;
    logic [RES_W-1:0] row1_mod0;
    logic [RES_W-1:0] row0_mod1;
    logic [RES_W-1:0] row1_mod1;
    logic             sum_overflow;
  } out_item_t;

  typedef struct packed {
    logic [LANES-1:0][SUM_W-1:0] sums;
    logic                        overflow;
  } acc_entry_t;

endpackage

// ===== hw/rtl/dmdp_front.sv =====
// ----------------------------------------------------------------------------
// dmdp_front
// Input stage: four residue multipliers, then 64-bit accumulators.
// ----------------------------------------------------------------------------
module dmdp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  dmdp_pkg::in_item_t  in_item,
  input  logic [dmdp_pkg::QCNT_W-1:0] q_count,
  output logic                q_push,
  output dmdp_pkg::acc_entry_t q_data
);
  import dmdp_pkg::*;

  logic                         prod_valid;
  logic                         prod_last;
  logic [LANES-1:0][PROD_W-1:0] prod;
  logic [LANES-1:0][SUM_W-1:0]  sums;
  logic [LANES-1:0][SUM_W-1:0]  sums_next;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  logic                         accept;
  logic [QCNT_W:0]              reserved;

  // a last item in flight holds a queue slot
  assign reserved = {1'b0, q_count} + {{QCNT_W{1'b0}}, prod_valid & prod_last};
  assign full     = reserved >= (QCNT_W+1)'(QDEPTH);
  assign accept   = push & ~full;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod[LANE_R0M0] <= {{RES_W{1'b0}}, in_item.qa_row0_res0} * {{RES_W{1'b0}}, in_item.db_res0};
      prod[LANE_R1M0] <= {{RES_W{1'b0}}, in_item.qa_row1_res0} * {{RES_W{1'b0}}, in_item.db_res0};
      prod[LANE_R0M1] <= {{RES_W{1'b0}}, in_item.qa_row0_res1} * {{RES_W{1'b0}}, in_item.db_res1};
      prod[LANE_R1M1] <= {{RES_W{1'b0}}, in_item.qa_row1_res1} * {{RES_W{1'b0}}, in_item.db_res1};
      prod_last       <= in_item.last_term;
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sums_next[i] = sums[i] + {{(SUM_W-PROD_W){1'b0}}, prod[i]};
    end
    count_next = (count <= MAX_CNT) ? count + CNT_W'(1) : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sums  <= '0;
      count <= '0;
    end else if (prod_valid) begin
      if (prod_last) begin
        sums  <= '0;
        count <= '0;
      end else begin
        sums  <= sums_next;
        count <= count_next;
      end
    end
  end

  assign q_push          = prod_valid & prod_last;
  assign q_data.sums     = sums_next;
  assign q_data.overflow = count_next > MAX_CNT;

endmodule

// ===== hw/rtl/dmdp_queue.sv =====
// ----------------------------------------------------------------------------
// dmdp_queue
// Two-entry queue of finished sums between front and back.
// ----------------------------------------------------------------------------
module dmdp_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         pop,
  output logic                         empty,
  output logic [dmdp_pkg::QCNT_W-1:0] count,
  input  dmdp_pkg::acc_entry_t         wr_data,
  output dmdp_pkg::acc_entry_t         rd_data
);
  import dmdp_pkg::*;

  acc_entry_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              do_push;
  logic              do_pop;

  assign do_push = push;
  assign do_pop  = pop & (count != '0);

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign rd_data = mem[rd_ptr];
  assign empty   = count == '0;

endmodule

// ===== hw/rtl/dmdp_back.sv =====
// ----------------------------------------------------------------------------
// dmdp_back
// Reduces four 64-bit sums by restoring division, one bit per cycle,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module dmdp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  dmdp_pkg::acc_entry_t        q_data,
  input  logic [dmdp_pkg::RES_W-1:0]  modulus_0,
  input  logic [dmdp_pkg::RES_W-1:0]  modulus_1,
  output logic                        empty,
  input  logic                        pop,
  output dmdp_pkg::out_item_t         out_item
);
  import dmdp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [STEP_W-1:0]           step;
  logic [LANES-1:0][SUM_W-1:0] dividend;
  logic [LANES-1:0][RES_W-1:0] rem;
  logic [LANES-1:0][RES_W-1:0] rem_next;
  logic [LANES-1:0][RES_W-1:0] lane_mod;
  logic                        overflow;
  logic                        out_valid;
  logic                        out_load;
  logic                        m0_ok;
  logic                        m1_ok;

  assign lane_mod[LANE_R0M0] = modulus_0;
  assign lane_mod[LANE_R1M0] = modulus_0;
  assign lane_mod[LANE_R0M1] = modulus_1;
  assign lane_mod[LANE_R1M1] = modulus_1;

  always_comb begin
    logic [RES_W:0] shifted;
    shifted = '0;
    for (int i = 0; i < LANES; i++) begin
      shifted = {rem[i], dividend[i][SUM_W-1]};
      if (shifted >= {1'b0, lane_mod[i]}) begin
        shifted = shifted - {1'b0, lane_mod[i]};
      end
      rem_next[i] = shifted[RES_W-1:0];
    end
  end

  assign q_pop    = (state == ST_IDLE) & ~q_empty;
  assign out_load = (state == ST_DONE) & (~out_valid | pop);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (!q_empty) state_next = ST_RUN;
      ST_RUN:  if (step == LAST_STEP) state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dividend <= q_data.sums;
      overflow <= q_data.overflow;
      rem      <= '0;
      step     <= '0;
    end else if (state == ST_RUN) begin
      for (int i = 0; i < LANES; i++) begin
        dividend[i] <= {dividend[i][SUM_W-2:0], 1'b0};
      end
      rem  <= rem_next;
      step <= step + STEP_W'(1);
    end
  end

  // moduli below two give zero
  assign m0_ok = modulus_0 > RES_W'(1);
  assign m1_ok = modulus_1 > RES_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.row0_mod0    <= m0_ok ? rem[LANE_R0M0] : '0;
      out_item.row1_mod0    <= m0_ok ? rem[LANE_R1M0] : '0;
      out_item.row0_mod1    <= m1_ok ? rem[LANE_R0M1] : '0;
      out_item.row1_mod1    <= m1_ok ? rem[LANE_R1M1] : '0;
      out_item.sum_overflow <= overflow;
    end
  end

  assign empty = ~out_valid;

endmodule

// ===== hw/rtl/dual_modulus_dot_product_core.sv =====
// ----------------------------------------------------------------------------
// dual_modulus_dot_product_core
// Two-modulus RNS dot product: multiply-accumulate front, reducing back.
// ----------------------------------------------------------------------------
// Throughput: one term per cycle while the two-entry sum queue has room (full low);
//   the reducer works on one sum at a time and takes the next only when idle again.
// Path of a last term: multiply register, accumulate into the queue, 64 divide steps.
// The divide loop (one quotient bit per cycle, four lanes) sets the per-result time.
// Reset: synchronous; clears sums, term count, queue, output; moduli to defaults.
module dual_modulus_dot_product_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  dmdp_pkg::in_item_t                 in_item,
  output logic                               empty,
  input  logic                               pop,
  output dmdp_pkg::out_item_t                out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dmdp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmdp_pkg::RES_W-1:0]         cfg_data
);
  import dmdp_pkg::*;

  logic [RES_W-1:0] modulus_0;
  logic [RES_W-1:0] modulus_1;
  logic [QCNT_W-1:0] q_count;
  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  acc_entry_t        q_wr_data;
  acc_entry_t        q_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_0 <= MODULUS_0_RST;
      modulus_1 <= MODULUS_1_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODULUS_0: modulus_0 <= cfg_data;
        CFG_MODULUS_1: modulus_1 <= cfg_data;
        default: ;
      endcase
    end
  end

  dmdp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_count (q_count),
    .q_push  (q_push),
    .q_data  (q_wr_data)
  );

  dmdp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .pop     (q_pop),
    .empty   (q_empty),
    .count   (q_count),
    .wr_data (q_wr_data),
    .rd_data (q_rd_data)
  );

  dmdp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rd_data),
    .modulus_0 (modulus_0),
    .modulus_1 (modulus_1),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dual_modulus_dot_product_core. Dot-product terms are
// queued per phase and pushed under random sender idling. Each accepted term
// updates a local four-lane accumulator, and each final term produces a
// predicted result. Popped results are checked in order under random receiver
// stalls. Moduli are reprogrammed between phases: extremes, degenerate values,
// random values and the defaults.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dmdp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
  localparam logic [RES_W-1:0]     RES_MAX   = '1;
  localparam int                   DRAIN_CYCLES   = 100;
  localparam longint               TIMEOUT_CYCLES = 2_000_000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 push      = 1'b0;
  logic                 full;
  in_item_t             in_item   = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RES_W-1:0]     cfg_data  = '0;

  in_item_t  pending_terms[$];
  out_item_t expected_sums[$];
  out_item_t predicted;
  out_item_t want;

  // local accumulator state and modulus copies
  bit [SUM_W-1:0] lane_sum [LANES];
  bit [CNT_W-1:0] terms_in_sum = '0;
  bit [RES_W-1:0] mod0_cfg = MODULUS_0_RST;
  bit [RES_W-1:0] mod1_cfg = MODULUS_1_RST;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int terms_queued     = 0;
  int terms_accepted   = 0;
  int results_checked  = 0;
  int overflow_results = 0;
  int mismatch_count   = 0;
  int fail_count       = 0;
  int settings_used    = 0;

  dual_modulus_dot_product_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit [RES_W-1:0] reduce_lane(bit [SUM_W-1:0] s, bit [RES_W-1:0] m);
    if (m < 2) return '0;
    return RES_W'(s % SUM_W'(m));
  endfunction

  // adds one term; returns 1 with the reduced sums when the term closes the sum
  function automatic bit dot_accumulate(in_item_t t, output out_item_t res);
    lane_sum[LANE_R0M0] += SUM_W'(t.qa_row0_res0) * SUM_W'(t.db_res0);
    lane_sum[LANE_R1M0] += SUM_W'(t.qa_row1_res0) * SUM_W'(t.db_res0);
    lane_sum[LANE_R0M1] += SUM_W'(t.qa_row0_res1) * SUM_W'(t.db_res1);
    lane_sum[LANE_R1M1] += SUM_W'(t.qa_row1_res1) * SUM_W'(t.db_res1);
    if (terms_in_sum <= MAX_CNT) terms_in_sum += 1'b1;
    res = '0;
    if (!t.last_term) return 1'b0;
    res.row0_mod0    = reduce_lane(lane_sum[LANE_R0M0], mod0_cfg);
    res.row1_mod0    = reduce_lane(lane_sum[LANE_R1M0], mod0_cfg);
    res.row0_mod1    = reduce_lane(lane_sum[LANE_R0M1], mod1_cfg);
    res.row1_mod1    = reduce_lane(lane_sum[LANE_R1M1], mod1_cfg);
    res.sum_overflow = terms_in_sum > MAX_CNT;
    foreach (lane_sum[i]) lane_sum[i] = '0;
    terms_in_sum = '0;
    return 1'b1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        terms_accepted++;
        if (dot_accumulate(in_item, predicted))
          expected_sums.insert(expected_sums.size(), predicted);
      end
      if (!push || !full) begin
        if (pending_terms.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push    <= 1'b1;
          in_item <= pending_terms.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_sums.size() == 0) begin
          fail_count++;
          $display("tb: result with nothing expected: %h %h %h %h ovf %b",
                   out_item.row0_mod0, out_item.row1_mod0, out_item.row0_mod1,
                   out_item.row1_mod1, out_item.sum_overflow);
        end else begin
          want = expected_sums.pop_front();
          results_checked++;
          if (want.sum_overflow) overflow_results++;
          if (out_item.row0_mod0 !== want.row0_mod0 || out_item.row1_mod0 !== want.row1_mod0 ||
              out_item.row0_mod1 !== want.row0_mod1 || out_item.row1_mod1 !== want.row1_mod1 ||
              out_item.sum_overflow !== want.sum_overflow) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("tb: mismatch on result %0d (exp/act): r0m0 %h/%h r1m0 %h/%h",
                       results_checked, want.row0_mod0, out_item.row0_mod0,
                       want.row1_mod0, out_item.row1_mod0);
              $display("tb:   r0m1 %h/%h r1m1 %h/%h ovf %b/%b",
                       want.row0_mod1, out_item.row0_mod1, want.row1_mod1, out_item.row1_mod1,
                       want.sum_overflow, out_item.sum_overflow);
            end
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RES_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MODULUS_0) mod0_cfg = value;
    else if (idx == CFG_MODULUS_1) mod1_cfg = value;
  endtask

  task automatic set_moduli(logic [RES_W-1:0] m0, logic [RES_W-1:0] m1);
    write_reg(CFG_MODULUS_0, m0);
    write_reg(CFG_MODULUS_1, m1);
    settings_used++;
  endtask

  // waits until every queued term is taken and every result is back
  task automatic drain();
    while (terms_accepted != terms_queued) @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic bit [RES_W-1:0] random_modulus();
    return RES_W'($urandom_range(32'h0FFF_FFFF, 2));
  endfunction

  function automatic bit [RES_W-1:0] pick_residue(bit [RES_W-1:0] m);
    case ($urandom_range(7))
      0:       return '0;
      1:       return RES_MAX;
      2:       return m;
      3:       return m - 1'b1;
      4:       return RES_W'($urandom_range(255));
      default: return RES_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_term(bit [RES_W-1:0] d0, bit [RES_W-1:0] d1,
                                         bit [RES_W-1:0] q00, bit [RES_W-1:0] q01,
                                         bit [RES_W-1:0] q10, bit [RES_W-1:0] q11, bit last);
    in_item_t t;
    t.db_res0      = d0;
    t.db_res1      = d1;
    t.qa_row0_res0 = q00;
    t.qa_row0_res1 = q01;
    t.qa_row1_res0 = q10;
    t.qa_row1_res1 = q11;
    t.last_term    = last;
    return t;
  endfunction

  function automatic in_item_t random_term(bit last);
    return make_term(pick_residue(mod0_cfg), pick_residue(mod1_cfg),
                     pick_residue(mod0_cfg), pick_residue(mod1_cfg),
                     pick_residue(mod0_cfg), pick_residue(mod1_cfg), last);
  endfunction

  task automatic queue_term(in_item_t t);
    pending_terms.insert(pending_terms.size(), t);
    terms_queued++;
  endtask

  task automatic queue_dot_product(int len, bit full_scale);
    for (int i = 0; i < len; i++) begin
      if (full_scale)
        queue_term(make_term(RES_MAX, RES_MAX, RES_MAX, RES_MAX, RES_MAX, RES_MAX, i == len - 1));
      else
        queue_term(random_term(i == len - 1));
    end
  endtask

  // mostly complete dot products, some runs of terms with random last flags
  task automatic random_batch(int n);
    int target;
    int len;
    target = terms_queued + n;
    while (terms_queued < target) begin
      if ($urandom_range(99) < 85) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
        queue_dot_product(len, 1'b0);
      end else begin
        repeat ($urandom_range(8, 1)) queue_term(random_term($urandom_range(1)));
      end
    end
    queue_term(random_term(1'b1));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed terms at the reset moduli
    queue_term(make_term('0, '0, '0, '0, '0, '0, 1'b1));
    queue_term(make_term(RES_MAX, RES_MAX, RES_MAX, RES_MAX, RES_MAX, RES_MAX, 1'b1));
    queue_term(make_term(MODULUS_0_RST, MODULUS_1_RST, MODULUS_0_RST, MODULUS_1_RST,
                         MODULUS_0_RST, MODULUS_1_RST, 1'b1));
    queue_term(make_term(MODULUS_0_RST - 1'b1, MODULUS_1_RST - 1'b1, MODULUS_0_RST - 1'b1,
                         MODULUS_1_RST - 1'b1, MODULUS_0_RST - 1'b1, MODULUS_1_RST - 1'b1,
                         1'b1));
    queue_term(make_term(RES_MAX, 1, 1, 1, 1, 1, 1'b1));
    queue_term(make_term(1, RES_MAX, 1, 1, 1, 1, 1'b1));
    queue_term(make_term(1, 1, RES_MAX, 1, 1, 1, 1'b1));
    queue_term(make_term(1, 1, 1, RES_MAX, 1, 1, 1'b1));
    queue_term(make_term(1, 1, 1, 1, RES_MAX, 1, 1'b1));
    queue_term(make_term(1, 1, 1, 1, 1, RES_MAX, 1'b1));
    for (int i = 0; i < 4; i++)
      queue_term(make_term((i % 2) ? 28'hAAAAAAA : 28'h5555555,
                           (i % 2) ? 28'h5555555 : 28'hAAAAAAA,
                           28'hAAAAAAA, 28'h5555555, 28'h5555555, 28'hAAAAAAA, i == 3));
    queue_term(make_term(RES_MAX, '0, '0, RES_MAX, RES_MAX, '0, 1'b0));
    queue_term(make_term('0, RES_MAX, RES_MAX, '0, '0, RES_MAX, 1'b0));
    queue_term(make_term(RES_MAX, RES_MAX, '0, '0, RES_MAX, RES_MAX, 1'b0));
    queue_term(make_term(MODULUS_0_RST, MODULUS_1_RST, 2, 3, 5, 7, 1'b1));
    drain();

    set_moduli(RES_MAX, 28'd2);
    random_batch(100);
    drain();

    send_idle_pct = 62;
    set_moduli(random_modulus(), random_modulus());
    random_batch(60);
    queue_dot_product(MAX_TERMS + 1, 1'b0);
    random_batch(60);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 62;
    set_moduli('0, 28'd1);
    write_reg(CFG_SPARE, RES_W'($urandom));
    random_batch(80);
    drain();

    send_idle_pct  = 23;
    recv_stall_pct = 23;
    set_moduli(28'd2, RES_MAX);
    queue_dot_product(MAX_TERMS, 1'b1);
    random_batch(100);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_moduli(random_modulus(), random_modulus());
    random_batch(60);
    drain();
    random_batch(60);
    queue_dot_product(2 * MAX_TERMS + 4, 1'b1);
    drain();

    send_idle_pct  = 23;
    recv_stall_pct = 23;
    set_moduli(random_modulus(), random_modulus());
    random_batch(100);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 62;
    set_moduli(MODULUS_0_RST, MODULUS_1_RST);
    random_batch(80);
    drain();

    fail_count += expected_sums.size();
    $display("tb: %0d terms accepted over %0d modulus settings, %0d results checked",
             terms_accepted, settings_used, results_checked);
    $display("tb: %0d results flagged overflow, %0d mismatches",
             overflow_results, mismatch_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("tb: timeout with %0d results outstanding", expected_sums.size());
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dmdp_pkg.sv
hw/rtl/dmdp_front.sv
hw/rtl/dmdp_queue.sv
hw/rtl/dmdp_back.sv
hw/rtl/dual_modulus_dot_product_core.sv
sim/testbench.sv
